// ----- design/csc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the cordic sine and cosine pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

	localparam int unsigned PHASE_W        = 32;
	localparam int unsigned OUT_W          = 34;
	// x and y stay below 2^32 in magnitude, z below 2^31
	localparam int unsigned XW             = 34;
	localparam int unsigned ZW             = 33;
	localparam int unsigned ATAN_W         = 30;
	localparam int unsigned ATAN_LEN       = 31;
	localparam int unsigned ATAN_IW        = $clog2(ATAN_LEN);
	localparam int unsigned ITERATIONS_DEF = 31;

	localparam logic signed [XW-1:0] GAIN_K  = 34'sd1304065748;
	localparam logic signed [XW-1:0] MAX_Q31 = 34'sd2147483647;
	localparam logic signed [OUT_W-1:0] ONE_Q32 = 34'sd4294967296;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [PHASE_W-1:0] OFFSET_MASK  = 32'h3fff_ffff;

	// quadrant codes, taken from the top two phase bits
	localparam logic [1:0] QUAD_ZERO    = 2'd0;
	localparam logic [1:0] QUAD_QUARTER = 2'd1;
	localparam logic [1:0] QUAD_HALF    = 2'd2;
	localparam logic [1:0] QUAD_THREE   = 2'd3;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic [ATAN_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1,
		30'd1
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} lane_t;

	typedef struct packed {
		lane_t      sin_l;
		lane_t      cos_l;
		logic       neg_sin;
		logic       neg_cos;
		logic       exact;
		logic [1:0] quad;
	} item_t;

endpackage
`default_nettype wire

// ----- design/cordic_sine_cosine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_sine_cosine
// Sine and cosine of a 32-bit phase (2^32 is a full turn) in signed Q2.32.
//
// Input channel in_valid/in_ready carries phase; output channel
// out_valid/out_ready carries sine and cosine of the same transaction.
// Pipeline: one fold stage, ITERATIONS cordic micro-rotation stages (one
// micro-rotation per lane per stage) and one output stage.
// Throughput is one transaction per cycle while out_ready is high; every stage
// has its own valid bit and ready, so bubbles are squeezed out and a phase is
// still accepted while a finished result waits, until the pipeline is full.
// When out_ready is low the output holds and the stages fill behind it;
// nothing is dropped or repeated. Axis phases return exact 0 and +-2^32.
// Reset clears all valid bits, so a transaction can be taken as soon as
// arst_n is released.
// ----------------------------------------------------------------------------
module cordic_sine_cosine #(
	parameter int unsigned ITERATIONS = csc_pkg::ITERATIONS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [csc_pkg::PHASE_W-1:0]        phase,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [csc_pkg::OUT_W-1:0]        sine,
	output logic signed [csc_pkg::OUT_W-1:0]        cosine
);
	import csc_pkg::*;

	logic  fold_valid;
	logic  fold_ready;
	item_t fold_item;
	logic  core_valid;
	logic  core_ready;
	item_t core_item;

	csc_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.phase     (phase),
		.out_valid (fold_valid),
		.out_ready (fold_ready),
		.out_item  (fold_item)
	);

	csc_core #(
		.ITERATIONS (ITERATIONS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fold_valid),
		.in_ready  (fold_ready),
		.in_item   (fold_item),
		.out_valid (core_valid),
		.out_ready (core_ready),
		.out_item  (core_item)
	);

	csc_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (core_valid),
		.in_ready  (core_ready),
		.in_item   (core_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sine      (sine),
		.cosine    (cosine)
	);

endmodule
`default_nettype wire

// ----- design/csc_fold.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csc_fold
// Input stage: folds the phase and the phase plus a quarter turn into the
// first quadrant and loads the starting cordic vectors.
// ----------------------------------------------------------------------------
module csc_fold (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [csc_pkg::PHASE_W-1:0] phase,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output csc_pkg::item_t                    out_item
);
	import csc_pkg::*;

	logic                item_valid_s1;
	item_t               item_s1;
	item_t               folded;
	logic [PHASE_W-1:0]  phase_cos;

	function automatic lane_t fold_lane(logic [PHASE_W-1:0] ph);
		lane_t      l;
		logic [30:0] zv;
		// odd quadrants count down from a quarter turn
		if (ph[30]) begin
			zv = QUARTER_TURN[30:0] - {1'b0, ph[29:0]};
		end else begin
			zv = {1'b0, ph[29:0]};
		end
		l.x = GAIN_K;
		l.y = '0;
		l.z = $signed({{(ZW-31){1'b0}}, zv});
		return l;
	endfunction

	assign phase_cos = phase + QUARTER_TURN;

	always_comb begin
		folded.sin_l   = fold_lane(phase);
		folded.cos_l   = fold_lane(phase_cos);
		folded.neg_sin = phase[31];
		folded.neg_cos = phase_cos[31];
		folded.exact   = ((phase & OFFSET_MASK) == '0);
		folded.quad    = phase[31:30];
	end

	assign in_ready  = !item_valid_s1 || out_ready;
	assign out_valid = item_valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= folded;
		end
	end

`ifndef SYNTHESIS
	// folded angle lies in [0, quarter turn]
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 |-> !item_s1.sin_l.z[ZW-1] && !item_s1.cos_l.z[ZW-1]
			&& item_s1.sin_l.z <= $signed({1'b0, QUARTER_TURN})
			&& item_s1.cos_l.z <= $signed({1'b0, QUARTER_TURN}))
		else $error("folded angle out of range");
`endif

endmodule
`default_nettype wire

// ----- design/csc_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csc_core
// Unrolled rotation-mode cordic, one micro-rotation per register stage,
// sine and cosine lanes side by side.
// ----------------------------------------------------------------------------
module csc_core #(
	parameter int unsigned ITERATIONS = csc_pkg::ITERATIONS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire csc_pkg::item_t  in_item,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output csc_pkg::item_t       out_item
);
	import csc_pkg::*;

	logic  item_valid_s2 [ITERATIONS];
	item_t item_s2       [ITERATIONS];
	logic  stage_ready   [ITERATIONS];

	// shift right, rounding toward zero
	function automatic logic signed [XW-1:0] shr_trunc(logic signed [XW-1:0] v,
			logic [ATAN_IW-1:0] s);
		logic signed [XW-1:0] r;
		if (v[XW-1]) begin
			r = -((-v) >>> s);
		end else begin
			r = v >>> s;
		end
		return r;
	endfunction

	function automatic lane_t rotate_lane(lane_t l, logic [ATAN_IW-1:0] i);
		lane_t                r;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic signed [ZW-1:0] at;
		xs = shr_trunc(l.x, i);
		ys = shr_trunc(l.y, i);
		at = $signed({{(ZW-ATAN_W){1'b0}}, ATAN_TURNS[i]});
		if (!l.z[ZW-1]) begin
			r.x = l.x - ys;
			r.y = l.y + xs;
			r.z = l.z - at;
		end else begin
			r.x = l.x + ys;
			r.y = l.y - xs;
			r.z = l.z + at;
		end
		return r;
	endfunction

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
		logic  prev_valid;
		item_t prev_item;
		item_t rot_item;
		logic  next_ready;

		if (k == 0) begin : g_first
			assign prev_valid = in_valid;
			assign prev_item  = in_item;
		end else begin : g_chain
			assign prev_valid = item_valid_s2[k-1];
			assign prev_item  = item_s2[k-1];
		end

		if (k == ITERATIONS - 1) begin : g_last
			assign next_ready = out_ready;
		end else begin : g_mid
			assign next_ready = stage_ready[k+1];
		end

		assign stage_ready[k] = !item_valid_s2[k] || next_ready;

		always_comb begin
			rot_item       = prev_item;
			rot_item.sin_l = rotate_lane(prev_item.sin_l, ATAN_IW'(k));
			rot_item.cos_l = rotate_lane(prev_item.cos_l, ATAN_IW'(k));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				item_valid_s2[k] <= 1'b0;
			end else if (stage_ready[k]) begin
				item_valid_s2[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[k] && prev_valid) begin
				item_s2[k] <= rot_item;
			end
		end
	end

	assign in_ready  = stage_ready[0];
	assign out_valid = item_valid_s2[ITERATIONS-1];
	assign out_item  = item_s2[ITERATIONS-1];

`ifndef SYNTHESIS
	// a transaction taken in lands in the first rotation stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && stage_ready[0] |=> item_valid_s2[0])
		else $error("accepted transaction lost at first stage");

	// a stalled last stage keeps its transaction intact
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s2[ITERATIONS-1] && !out_ready
			|=> item_valid_s2[ITERATIONS-1] && $stable(item_s2[ITERATIONS-1]))
		else $error("stalled rotation stage changed");
`endif

endmodule
`default_nettype wire

// ----- design/csc_finish.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csc_finish
// Output stage: restores the sign, clamps, doubles to Q2.32 and substitutes
// the exact values on the four axis phases.
// ----------------------------------------------------------------------------
module csc_finish (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire csc_pkg::item_t                     in_item,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [csc_pkg::OUT_W-1:0]        sine,
	output logic signed [csc_pkg::OUT_W-1:0]        cosine
);
	import csc_pkg::*;

	logic                    out_valid_s3;
	logic signed [OUT_W-1:0] sine_s3;
	logic signed [OUT_W-1:0] cosine_s3;
	logic signed [OUT_W-1:0] sine_nx;
	logic signed [OUT_W-1:0] cosine_nx;

	function automatic logic signed [OUT_W-1:0] scale(logic signed [XW-1:0] y,
			logic neg);
		logic signed [XW-1:0] yn;
		logic signed [XW-1:0] yc;
		yn = neg ? -y : y;
		if (yn > MAX_Q31) begin
			yc = MAX_Q31;
		end else if (yn < -MAX_Q31) begin
			yc = -MAX_Q31;
		end else begin
			yc = yn;
		end
		return {yc[OUT_W-2:0], 1'b0};
	endfunction

	always_comb begin
		sine_nx   = scale(in_item.sin_l.y, in_item.neg_sin);
		cosine_nx = scale(in_item.cos_l.y, in_item.neg_cos);
		if (in_item.exact) begin
			case (in_item.quad)
				QUAD_ZERO: begin
					sine_nx   = '0;
					cosine_nx = ONE_Q32;
				end
				QUAD_QUARTER: begin
					sine_nx   = ONE_Q32;
					cosine_nx = '0;
				end
				QUAD_HALF: begin
					sine_nx   = '0;
					cosine_nx = -ONE_Q32;
				end
				QUAD_THREE: begin
					sine_nx   = -ONE_Q32;
					cosine_nx = '0;
				end
				default: begin
					sine_nx   = '0;
					cosine_nx = '0;
				end
			endcase
		end
	end

	assign in_ready  = !out_valid_s3 || out_ready;
	assign out_valid = out_valid_s3;
	assign sine      = sine_s3;
	assign cosine    = cosine_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s3 <= 1'b0;
		end else if (in_ready) begin
			out_valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sine_s3   <= sine_nx;
			cosine_s3 <= cosine_nx;
		end
	end

`ifndef SYNTHESIS
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s3 |-> sine_s3 <= ONE_Q32 && sine_s3 >= -ONE_Q32
			&& cosine_s3 <= ONE_Q32 && cosine_s3 >= -ONE_Q32)
		else $error("result beyond unit magnitude");

	// axis phases give one zero and one unit result
	a_exact: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.exact
			|=> (sine_s3 == '0 && (cosine_s3 == ONE_Q32 || cosine_s3 == -ONE_Q32))
			|| (cosine_s3 == '0 && (sine_s3 == ONE_Q32 || sine_s3 == -ONE_Q32)))
		else $error("axis phase gave inexact result");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks cordic_sine_cosine against a bit-accurate predictor of the folded
// cordic. Phases go in through a bursty driver, results are taken by a
// monitor with its own stall pattern and compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import csc_pkg::*;

	localparam logic [PHASE_W-1:0] PH_ZERO  = 32'h0000_0000;
	localparam logic [PHASE_W-1:0] PH_HALF  = 32'h8000_0000;
	localparam logic [PHASE_W-1:0] PH_THREE = 32'hc000_0000;
	localparam int unsigned TAIL_CYCLES = 2 * (ITERATIONS_DEF + 2) + 16;

	// receiver stall modes
	localparam int RX_STREAM = 0;
	localparam int RX_CHOPPY = 1;
	localparam int RX_LONG   = 2;

	typedef struct packed {
		logic [PHASE_W-1:0]      phase;
		logic signed [OUT_W-1:0] sine;
		logic signed [OUT_W-1:0] cosine;
	} trig_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [PHASE_W-1:0]      phase = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [OUT_W-1:0] sine;
	logic signed [OUT_W-1:0] cosine;

	logic [PHASE_W-1:0] pending_phases [$];
	trig_t              expected_trig [$];
	int                 total_items = 0;
	int                 accepted_count = 0;
	int                 mismatch_count = 0;

	int burst_left = 0;
	int gap_left = 0;
	int rx_mode = RX_STREAM;
	int mode_left = 0;
	int stall_left = 0;
	trig_t got_trig;
	trig_t want_trig;

	cordic_sine_cosine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.phase     (phase),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sine      (sine),
		.cosine    (cosine)
	);

	always #4 clk = ~clk;

	function automatic longint shift_toward_zero(input longint v, input int s);
		if (v >= 0)
			return v >>> s;
		return -((-v) >>> s);
	endfunction

	// one quadrant-folded cordic lane, result in Q31 before doubling
	function automatic longint sine_core(input logic [PHASE_W-1:0] ph);
		logic [1:0] quad;
		longint x, y, z, xs, ys, nx, ny, step_angle, lim;
		quad = ph[31:30];
		lim = longint'(MAX_Q31);
		if (ph == PH_ZERO || ph == PH_HALF)
			return 0;
		if (ph == QUARTER_TURN)
			return lim;
		if (ph == PH_THREE)
			return -lim;
		if (quad == QUAD_ZERO || quad == QUAD_HALF)
			z = longint'(ph & OFFSET_MASK);
		else
			z = longint'(QUARTER_TURN) - longint'(ph & OFFSET_MASK);
		x = longint'(GAIN_K);
		y = 0;
		for (int i = 0; i < ITERATIONS_DEF && i < ATAN_LEN; i++) begin
			xs = shift_toward_zero(x, i);
			ys = shift_toward_zero(y, i);
			step_angle = longint'(ATAN_TURNS[i]);
			if (z >= 0) begin
				nx = x - ys;
				ny = y + xs;
				z = z - step_angle;
			end else begin
				nx = x + ys;
				ny = y - xs;
				z = z + step_angle;
			end
			x = nx;
			y = ny;
		end
		if (quad == QUAD_HALF || quad == QUAD_THREE)
			y = -y;
		if (y > lim)
			y = lim;
		if (y < -lim)
			y = -lim;
		return y;
	endfunction

	function automatic trig_t predict_sine_cosine(input logic [PHASE_W-1:0] ph);
		trig_t  t;
		longint s, c;
		t.phase = ph;
		if (ph == PH_ZERO) begin
			s = 0;
			c = longint'(ONE_Q32);
		end else if (ph == QUARTER_TURN) begin
			s = longint'(ONE_Q32);
			c = 0;
		end else if (ph == PH_HALF) begin
			s = 0;
			c = -longint'(ONE_Q32);
		end else if (ph == PH_THREE) begin
			s = -longint'(ONE_Q32);
			c = 0;
		end else begin
			s = sine_core(ph) * 2;
			c = sine_core(ph + QUARTER_TURN) * 2;
		end
		t.sine = s[OUT_W-1:0];
		t.cosine = c[OUT_W-1:0];
		return t;
	endfunction

	task automatic report_mismatch(input string what, input logic [PHASE_W-1:0] ph,
			input logic signed [OUT_W-1:0] got, input logic signed [OUT_W-1:0] want);
		$display("ERROR %0t: %s phase=%08h got %0d expected %0d", $realtime, what, ph, got,
			want);
		mismatch_count++;
	endtask

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			phase <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_trig.push_back(predict_sine_cosine(phase));
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_phases.size() > 0) begin
					in_valid <= 1'b1;
					phase <= pending_phases.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, switching mode every so often
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(RX_STREAM, RX_LONG);
				mode_left = $urandom_range(32, 256);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_STREAM: begin
					out_ready <= 1'b1;
				end
				RX_CHOPPY: begin
					out_ready <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
						if ($urandom_range(0, 7) == 0)
							stall_left = $urandom_range(5, 40);
					end
				end
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_trig.size() == 0) begin
				report_mismatch("result with nothing expected, sine", '0, sine, '0);
			end else begin
				want_trig = expected_trig.pop_front();
				got_trig.sine = sine;
				got_trig.cosine = cosine;
				if (got_trig.sine !== want_trig.sine)
					report_mismatch("sine", want_trig.phase, got_trig.sine, want_trig.sine);
				if (got_trig.cosine !== want_trig.cosine)
					report_mismatch("cosine", want_trig.phase, got_trig.cosine,
						want_trig.cosine);
			end
		end
	end

	initial begin
		logic [PHASE_W-1:0] axis;
		int pick;
		// axes, their neighbors, quadrant midpoints and bit patterns
		pending_phases = '{
			PH_ZERO, QUARTER_TURN, PH_HALF, PH_THREE,
			32'h0000_0001, 32'hffff_ffff, 32'h3fff_ffff, 32'h4000_0001,
			32'h7fff_ffff, 32'h8000_0001, 32'hbfff_ffff, 32'hc000_0001,
			32'h2000_0000, 32'h6000_0000, 32'ha000_0000, 32'he000_0000,
			32'h5555_5555, 32'haaaa_aaaa, 32'h4000_0002, 32'h3fff_fff0,
			32'h0000_0002, 32'hc000_0010
		};
		for (int n = 0; n < 900; n++) begin
			pick = $urandom_range(0, 9);
			axis = {2'($urandom_range(0, 3)), 30'd0};
			if (pick < 6)
				pending_phases.push_back($urandom);
			else if (pick < 8)
				pending_phases.push_back(axis + 32'($urandom_range(0, 1023)) - 32'd512);
			else if (pick < 9)
				pending_phases.push_back(axis);
			else
				pending_phases.push_back(32'd1 << $urandom_range(0, 31));
		end
		total_items = pending_phases.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_items || expected_trig.size() != 0)
			@(posedge clk);
		// let anything spurious still in flight show up
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("cordic_sine_cosine verification clean");
		else
			$display("cordic_sine_cosine verification failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("cordic_sine_cosine verification failed");
		$finish;
	end

endmodule
